// File: hw/rtl/sbca_pkg.sv
package sbca_pkg;

  // Limits of the geometry.
  localparam int MAX_SCREEN_WIDTH  = 1024;
  localparam int MAX_SCREEN_HEIGHT = 1024;
  localparam int MAX_SPRITE_WIDTH  = 256;
  localparam int MAX_SPRITE_HEIGHT = 256;

  // Field widths.
  localparam int SCR_SIZE_W = 11;
  localparam int SPR_SIZE_W = 9;
  localparam int ORG_W      = 11;
  localparam int COL_W      = $clog2(MAX_SPRITE_WIDTH);
  localparam int ROW_W      = $clog2(MAX_SPRITE_HEIGHT);
  localparam int XC_W       = $clog2(MAX_SCREEN_WIDTH);
  localparam int YC_W       = $clog2(MAX_SCREEN_HEIGHT);
  localparam int ADDR_W     = 20;
  localparam int CH_W       = 8;
  localparam int PROD_W     = 2 * CH_W;
  localparam int POS_W      = ORG_W + 1;

  // Stream payload widths.
  localparam int IN_DATA_W  = 8 * CH_W;
  localparam int OUT_DATA_W = 56;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPRITE_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPRITE_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_ENABLE  = 3'd6;

  localparam logic [SCR_SIZE_W-1:0] RST_SCREEN_WIDTH  = 11'd640;
  localparam logic [SCR_SIZE_W-1:0] RST_SCREEN_HEIGHT = 11'd480;
  localparam logic [SPR_SIZE_W-1:0] RST_SPRITE_WIDTH  = 9'd64;
  localparam logic [SPR_SIZE_W-1:0] RST_SPRITE_HEIGHT = 9'd64;

  localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'd255;
  localparam logic [CH_W-1:0] ALPHA_CLEAR  = 8'd0;

  // Queue between the front and back halves.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // What the back half does with an item.
  typedef enum logic [1:0] {
    CLS_SKIP,
    CLS_COPY,
    CLS_BLEND
  } cls_t;

  // Configuration, stored already clamped to the legal ranges.
  typedef struct packed {
    logic [SCR_SIZE_W-1:0]   scr_w;
    logic [SCR_SIZE_W-1:0]   scr_h;
    logic [SPR_SIZE_W-1:0]   spr_w;
    logic [SPR_SIZE_W-1:0]   spr_h;
    logic signed [ORG_W-1:0] org_x;
    logic signed [ORG_W-1:0] org_y;
    logic                    blend;
  } cfg_t;

  // One classified texel in the queue. Channel 0 is red, 1 green, 2 blue.
  typedef struct packed {
    cls_t                  cls;
    logic [XC_W-1:0]       x;
    logic [YC_W-1:0]       y;
    logic [3:0][CH_W-1:0]  tex;
    logic [3:0][CH_W-1:0]  dst;
    logic                  last;
  } q_item_t;

  // Clamp a screen size to its maximum.
  function automatic logic [SCR_SIZE_W-1:0] clamp_scr(input logic [SCR_SIZE_W-1:0] v,
                                                      input logic [SCR_SIZE_W-1:0] hi);
    clamp_scr = (v > hi) ? hi : v;
  endfunction

  // Clamp a sprite size to one at the least and its maximum at the most.
  function automatic logic [SPR_SIZE_W-1:0] clamp_spr(input logic [SPR_SIZE_W-1:0] v,
                                                      input logic [SPR_SIZE_W-1:0] hi);
    if (v == '0) begin
      clamp_spr = SPR_SIZE_W'(1);
    end else if (v > hi) begin
      clamp_spr = hi;
    end else begin
      clamp_spr = v;
    end
  endfunction

endpackage

// File: hw/rtl/sbca_front.sv
module sbca_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  sbca_pkg::cfg_t                  cfg,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [sbca_pkg::IN_DATA_W-1:0]  in_data,
  input  logic                            q_full,
  output logic                            q_push,
  output sbca_pkg::q_item_t               q_item
);

  logic [sbca_pkg::COL_W-1:0]      col_r, col_nxt;
  logic [sbca_pkg::ROW_W-1:0]      row_r, row_nxt;
  logic signed [sbca_pkg::POS_W-1:0] pos_x, pos_y;
  logic [sbca_pkg::SPR_SIZE_W-1:0] col_inc, row_inc;
  logic                            on_screen;
  logic                            is_last;
  logic [sbca_pkg::CH_W-1:0]       tex_a;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;
  assign tex_a    = in_data[4*sbca_pkg::CH_W-1:3*sbca_pkg::CH_W];

  // Screen position of the current texel and the clip test.
  always_comb begin
    pos_x  = $signed({cfg.org_x[sbca_pkg::ORG_W-1], cfg.org_x})
           + $signed({1'b0, (sbca_pkg::POS_W-1)'(col_r)});
    pos_y  = $signed({cfg.org_y[sbca_pkg::ORG_W-1], cfg.org_y})
           + $signed({1'b0, (sbca_pkg::POS_W-1)'(row_r)});
    on_screen = !pos_x[sbca_pkg::POS_W-1] && !pos_y[sbca_pkg::POS_W-1]
             && (pos_x[sbca_pkg::POS_W-2:0] < cfg.scr_w)
             && (pos_y[sbca_pkg::POS_W-2:0] < cfg.scr_h);
  end

  // Raster counters; a counter at or past its limit wraps.
  always_comb begin
    col_inc = sbca_pkg::SPR_SIZE_W'(col_r) + sbca_pkg::SPR_SIZE_W'(1);
    row_inc = sbca_pkg::SPR_SIZE_W'(row_r) + sbca_pkg::SPR_SIZE_W'(1);
    col_nxt = col_r;
    row_nxt = row_r;
    is_last = 1'b0;
    if (col_inc >= cfg.spr_w) begin
      col_nxt = '0;
      if (row_inc >= cfg.spr_h) begin
        row_nxt = '0;
        is_last = 1'b1;
      end else begin
        row_nxt = row_inc[sbca_pkg::ROW_W-1:0];
      end
    end else begin
      col_nxt = col_inc[sbca_pkg::COL_W-1:0];
    end
  end

  // Classify the texel and build the queue entry.
  always_comb begin
    q_item      = '0;
    q_item.x    = pos_x[sbca_pkg::XC_W-1:0];
    q_item.y    = pos_y[sbca_pkg::YC_W-1:0];
    q_item.last = is_last;
    for (int i = 0; i < 4; i++) begin
      q_item.tex[i] = in_data[i*sbca_pkg::CH_W +: sbca_pkg::CH_W];
      q_item.dst[i] = in_data[(i+4)*sbca_pkg::CH_W +: sbca_pkg::CH_W];
    end
    priority if (!on_screen) begin
      q_item.cls = sbca_pkg::CLS_SKIP;
    end else if (!cfg.blend || tex_a == sbca_pkg::ALPHA_OPAQUE) begin
      q_item.cls = sbca_pkg::CLS_COPY;
    end else if (tex_a == sbca_pkg::ALPHA_CLEAR) begin
      q_item.cls = sbca_pkg::CLS_SKIP;
    end else begin
      q_item.cls = sbca_pkg::CLS_BLEND;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (q_push) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

// File: hw/rtl/sbca_queue.sv
module sbca_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sbca_pkg::q_item_t push_item,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output sbca_pkg::q_item_t head
);

  sbca_pkg::q_item_t            mem [sbca_pkg::QUEUE_DEPTH];
  logic [sbca_pkg::QUEUE_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [sbca_pkg::QUEUE_AW:0]   count_r, count_nxt;

  assign full      = (count_r == (sbca_pkg::QUEUE_AW+1)'(sbca_pkg::QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (sbca_pkg::QUEUE_AW+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (sbca_pkg::QUEUE_AW+1)'(1);
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + sbca_pkg::QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + sbca_pkg::QUEUE_AW'(1);
      end
      count_r <= count_nxt;
    end
  end

endmodule

// File: hw/rtl/sbca_back.sv
module sbca_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [sbca_pkg::SCR_SIZE_W-1:0]   scr_w,
  input  logic                              q_not_empty,
  input  sbca_pkg::q_item_t                 q_head,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_we,
  output logic [sbca_pkg::ADDR_W-1:0]       out_addr,
  output logic [3:0][sbca_pkg::CH_W-1:0]    out_color,
  output logic                              out_last
);

  // Products stage.
  typedef struct packed {
    sbca_pkg::cls_t                       cls;
    logic [sbca_pkg::XC_W-1:0]            x;
    logic [sbca_pkg::ADDR_W-1:0]          row_base;
    logic [2:0][sbca_pkg::PROD_W-1:0]     pt;
    logic [2:0][sbca_pkg::PROD_W-1:0]     pd;
    logic [3:0][sbca_pkg::CH_W-1:0]       tex;
    logic [sbca_pkg::CH_W-1:0]            dst_a;
    logic                                 last;
  } s1_t;

  // Result register.
  typedef struct packed {
    logic                              we;
    logic [sbca_pkg::ADDR_W-1:0]       addr;
    logic [3:0][sbca_pkg::CH_W-1:0]    color;
    logic                              last;
  } res_t;

  s1_t                                  s1_r, s1_nxt;
  logic                                 s1_v_r;
  res_t                                 res_r, res_nxt;
  logic                                 res_v_r;
  logic                                 adv_res, adv_s1;
  logic [sbca_pkg::CH_W-1:0]            inv_a;
  logic [sbca_pkg::SCR_SIZE_W+sbca_pkg::YC_W-1:0] row_prod;
  logic [sbca_pkg::PROD_W:0]            mix_sum [3];
  logic [sbca_pkg::PROD_W:0]            mix_q   [3];

  assign adv_res = !res_v_r || out_ready;
  assign adv_s1  = !s1_v_r || adv_res;
  assign q_pop   = q_not_empty && adv_s1;

  assign out_valid = res_v_r;
  assign out_we    = res_r.we;
  assign out_addr  = res_r.addr;
  assign out_color = res_r.color;
  assign out_last  = res_r.last;

  // First stage: row offset and the weighted channel products.
  always_comb begin
    inv_a           = sbca_pkg::ALPHA_OPAQUE - q_head.tex[3];
    row_prod        = (sbca_pkg::SCR_SIZE_W+sbca_pkg::YC_W)'(q_head.y)
                    * (sbca_pkg::SCR_SIZE_W+sbca_pkg::YC_W)'(scr_w);
    s1_nxt          = '0;
    s1_nxt.cls      = q_head.cls;
    s1_nxt.x        = q_head.x;
    s1_nxt.row_base = row_prod[sbca_pkg::ADDR_W-1:0];
    s1_nxt.tex      = q_head.tex;
    s1_nxt.dst_a    = q_head.dst[3];
    s1_nxt.last     = q_head.last;
    for (int i = 0; i < 3; i++) begin
      s1_nxt.pt[i] = sbca_pkg::PROD_W'(q_head.tex[3]) * sbca_pkg::PROD_W'(q_head.tex[i]);
      s1_nxt.pd[i] = sbca_pkg::PROD_W'(inv_a) * sbca_pkg::PROD_W'(q_head.dst[i]);
    end
  end

  // Second stage: divide the blend sums by 255 and pick the result.
  // For sums up to 255*255, (v + 1 + (v >> 8)) >> 8 equals v / 255.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mix_sum[i] = (sbca_pkg::PROD_W+1)'(s1_r.pt[i]) + (sbca_pkg::PROD_W+1)'(s1_r.pd[i]);
      mix_q[i]   = (mix_sum[i] + (sbca_pkg::PROD_W+1)'(1)
                 + (mix_sum[i] >> sbca_pkg::CH_W)) >> sbca_pkg::CH_W;
    end
    res_nxt      = '0;
    res_nxt.last = s1_r.last;
    unique case (s1_r.cls)
      sbca_pkg::CLS_COPY: begin
        res_nxt.we    = 1'b1;
        res_nxt.addr  = s1_r.row_base + sbca_pkg::ADDR_W'(s1_r.x);
        res_nxt.color = s1_r.tex;
      end
      sbca_pkg::CLS_BLEND: begin
        res_nxt.we       = 1'b1;
        res_nxt.addr     = s1_r.row_base + sbca_pkg::ADDR_W'(s1_r.x);
        res_nxt.color[0] = mix_q[0][sbca_pkg::CH_W-1:0];
        res_nxt.color[1] = mix_q[1][sbca_pkg::CH_W-1:0];
        res_nxt.color[2] = mix_q[2][sbca_pkg::CH_W-1:0];
        res_nxt.color[3] = s1_r.dst_a;
      end
      default: begin
        res_nxt.we = 1'b0;
      end
    endcase
  end

  // Pipeline payload registers.
  always_ff @(posedge clk) begin
    if (adv_s1) begin
      s1_r <= s1_nxt;
    end
    if (adv_res) begin
      res_r <= res_nxt;
    end
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      res_v_r <= 1'b0;
    end else begin
      if (adv_s1) begin
        s1_v_r <= q_pop;
      end
      if (adv_res) begin
        res_v_r <= s1_v_r;
      end
    end
  end

endmodule

// File: hw/rtl/sprite_blit_clip_alpha.sv
// Sprite blitter with screen clipping and alpha blending.
// Throughput: one texel per cycle while out_tready is high; the four-entry queue
// and the two-stage back pipeline (products, then divide-by-255 and select) each
// take one per cycle.
// Reset (rst_n low, synchronous): counters, queue and pipeline empty, registers
// return to 640 x 480 screen, 64 x 64 sprite, origin 0, copy mode.
module sprite_blit_clip_alpha (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // tex_red, tex_green, tex_blue, tex_alpha, dst_red, dst_green, dst_blue, dst_alpha
  input  logic [sbca_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // pixel_address, out_red, out_green, out_blue, out_alpha, zero fill
  output logic [sbca_pkg::OUT_DATA_W-1:0]     out_tdata,
  // write_enable
  output logic [0:0]                          out_tuser,
  output logic                                out_tlast,
  input  logic                                cfg_we,
  input  logic [sbca_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sbca_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  sbca_pkg::cfg_t                          cfg_r, cfg_nxt;
  logic                                    q_full, q_push, q_pop, q_not_empty;
  sbca_pkg::q_item_t                       q_in, q_head;
  logic                                    res_we, res_last;
  logic [sbca_pkg::ADDR_W-1:0]             res_addr;
  logic [3:0][sbca_pkg::CH_W-1:0]          res_color;

  // Register writes, clamped to the legal ranges as they are stored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        sbca_pkg::REG_SCREEN_WIDTH:
          cfg_nxt.scr_w = sbca_pkg::clamp_scr(cfg_wdata[sbca_pkg::SCR_SIZE_W-1:0],
                            sbca_pkg::SCR_SIZE_W'(sbca_pkg::MAX_SCREEN_WIDTH));
        sbca_pkg::REG_SCREEN_HEIGHT:
          cfg_nxt.scr_h = sbca_pkg::clamp_scr(cfg_wdata[sbca_pkg::SCR_SIZE_W-1:0],
                            sbca_pkg::SCR_SIZE_W'(sbca_pkg::MAX_SCREEN_HEIGHT));
        sbca_pkg::REG_SPRITE_WIDTH:
          cfg_nxt.spr_w = sbca_pkg::clamp_spr(cfg_wdata[sbca_pkg::SPR_SIZE_W-1:0],
                            sbca_pkg::SPR_SIZE_W'(sbca_pkg::MAX_SPRITE_WIDTH));
        sbca_pkg::REG_SPRITE_HEIGHT:
          cfg_nxt.spr_h = sbca_pkg::clamp_spr(cfg_wdata[sbca_pkg::SPR_SIZE_W-1:0],
                            sbca_pkg::SPR_SIZE_W'(sbca_pkg::MAX_SPRITE_HEIGHT));
        sbca_pkg::REG_ORIGIN_X:
          cfg_nxt.org_x = $signed(cfg_wdata[sbca_pkg::ORG_W-1:0]);
        sbca_pkg::REG_ORIGIN_Y:
          cfg_nxt.org_y = $signed(cfg_wdata[sbca_pkg::ORG_W-1:0]);
        sbca_pkg::REG_BLEND_ENABLE:
          cfg_nxt.blend = cfg_wdata[0];
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scr_w <= sbca_pkg::RST_SCREEN_WIDTH;
      cfg_r.scr_h <= sbca_pkg::RST_SCREEN_HEIGHT;
      cfg_r.spr_w <= sbca_pkg::RST_SPRITE_WIDTH;
      cfg_r.spr_h <= sbca_pkg::RST_SPRITE_HEIGHT;
      cfg_r.org_x <= '0;
      cfg_r.org_y <= '0;
      cfg_r.blend <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front half: placement, clipping and classification.
  sbca_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_data  (in_tdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_in)
  );

  sbca_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // Back half: address and blend arithmetic.
  sbca_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .scr_w       (cfg_r.scr_w),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_we      (res_we),
    .out_addr    (res_addr),
    .out_color   (res_color),
    .out_last    (res_last)
  );

  // Output packing.
  assign out_tdata = {4'b0000, res_color[3], res_color[2], res_color[1], res_color[0],
                      res_addr};
  assign out_tuser = res_we;
  assign out_tlast = res_last;

endmodule

// File: tb/tb_sprite_blit_clip_alpha.sv
module tb_sprite_blit_clip_alpha;

  // Register index that lies beyond the register map; writes to it are dropped.
  localparam logic [sbca_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int TAIL_CYCLES    = 8;
  localparam int PHASES         = 12;
  localparam int TEXELS_PER_PHASE = 105;

  // One pixel write as it leaves the blitter.
  typedef struct packed {
    logic        we;
    logic [19:0] addr;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        last;
  } pixel_t;

  // One row of the directed plan: a register write or a texel transaction.
  typedef struct packed {
    logic                            is_cfg;
    logic [sbca_pkg::CFG_IDX_W-1:0]  idx;
    logic [sbca_pkg::CFG_DATA_W-1:0] val;
    logic [sbca_pkg::IN_DATA_W-1:0]  texel;
    logic                            typed;
    pixel_t                          pix;
  } plan_step_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [sbca_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [sbca_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [0:0]                      out_tuser;
  logic                            out_tlast;
  logic                            cfg_we = 1'b0;
  logic [sbca_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [sbca_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  sprite_blit_clip_alpha dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the blitter registers and raster counters.
  logic [sbca_pkg::SCR_SIZE_W-1:0]   scr_w = sbca_pkg::RST_SCREEN_WIDTH;
  logic [sbca_pkg::SCR_SIZE_W-1:0]   scr_h = sbca_pkg::RST_SCREEN_HEIGHT;
  logic [sbca_pkg::SPR_SIZE_W-1:0]   spr_w = sbca_pkg::RST_SPRITE_WIDTH;
  logic [sbca_pkg::SPR_SIZE_W-1:0]   spr_h = sbca_pkg::RST_SPRITE_HEIGHT;
  logic signed [sbca_pkg::ORG_W-1:0] org_x = '0;
  logic signed [sbca_pkg::ORG_W-1:0] org_y = '0;
  logic                              blend_on = 1'b0;
  int                                col_cnt = 0;
  int                                row_cnt = 0;

  pixel_t pixel_q[$];
  int     errors = 0;
  int     idle_cycles = 0;
  int     src_idle_pct = 0;
  int     snk_stall_pct = 0;
  int     hold_len = 0;
  logic   typed_pending = 1'b0;
  pixel_t typed_pix = '0;

  function automatic logic [7:0] blend_channel(input int a, input int t, input int d);
    return 8'((a * t + (255 - a) * d) / 255);
  endfunction

  // Place one texel on screen, clip it, blend it, and advance the raster counters.
  function automatic pixel_t blit_texel(input logic [sbca_pkg::IN_DATA_W-1:0] d);
    pixel_t p;
    int sw, sh, pw, ph, x, y, a;
    p  = '0;
    sw = (scr_w > sbca_pkg::MAX_SCREEN_WIDTH) ? sbca_pkg::MAX_SCREEN_WIDTH : scr_w;
    sh = (scr_h > sbca_pkg::MAX_SCREEN_HEIGHT) ? sbca_pkg::MAX_SCREEN_HEIGHT : scr_h;
    pw = (spr_w == 0) ? 1 :
         (spr_w > sbca_pkg::MAX_SPRITE_WIDTH) ? sbca_pkg::MAX_SPRITE_WIDTH : spr_w;
    ph = (spr_h == 0) ? 1 :
         (spr_h > sbca_pkg::MAX_SPRITE_HEIGHT) ? sbca_pkg::MAX_SPRITE_HEIGHT : spr_h;
    x  = org_x;
    x  = x + col_cnt;
    y  = org_y;
    y  = y + row_cnt;
    a  = d[31:24];

    if (x >= 0 && y >= 0 && x < sw && y < sh) begin
      if (!blend_on || a == sbca_pkg::ALPHA_OPAQUE) begin
        p.we = 1'b1;
        {p.alpha, p.blue, p.green, p.red} = d[31:0];
      end else if (a != sbca_pkg::ALPHA_CLEAR) begin
        p.we    = 1'b1;
        p.red   = blend_channel(a, d[7:0], d[39:32]);
        p.green = blend_channel(a, d[15:8], d[47:40]);
        p.blue  = blend_channel(a, d[23:16], d[55:48]);
        p.alpha = d[63:56];
      end
      if (p.we) begin
        p.addr = 20'(y * sw + x);
      end
    end

    // A counter at or past its limit wraps just like one at the last column or row.
    if (col_cnt + 1 >= pw) begin
      col_cnt = 0;
      if (row_cnt + 1 >= ph) begin
        row_cnt = 0;
        p.last  = 1'b1;
      end else begin
        row_cnt = row_cnt + 1;
      end
    end else begin
      col_cnt = col_cnt + 1;
    end
    return p;
  endfunction

  function automatic plan_step_t cfg_step(input logic [sbca_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [sbca_pkg::CFG_DATA_W-1:0] val);
    plan_step_t s;
    s        = '0;
    s.is_cfg = 1'b1;
    s.idx    = idx;
    s.val    = val;
    return s;
  endfunction

  function automatic plan_step_t texel_step(input logic [sbca_pkg::IN_DATA_W-1:0] d);
    plan_step_t s;
    s       = '0;
    s.texel = d;
    return s;
  endfunction

  // Texel with its pixel write spelled out; rgba is {red, green, blue, alpha}.
  function automatic plan_step_t typed_step(input logic [sbca_pkg::IN_DATA_W-1:0] d,
                                            input logic we,
                                            input logic [19:0] addr, input logic [31:0] rgba,
                                            input logic last);
    plan_step_t s;
    s          = '0;
    s.texel    = d;
    s.typed    = 1'b1;
    s.pix.we   = we;
    s.pix.addr = addr;
    {s.pix.red, s.pix.green, s.pix.blue, s.pix.alpha} = rgba;
    s.pix.last = last;
    return s;
  endfunction

  task automatic report_field(input string name, input int unsigned want,
                              input int unsigned got);
    if (want != got) begin
      errors = errors + 1;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Record every accepted texel and check every accepted pixel write.
  always @(posedge clk) begin : watch_pixels
    pixel_t got;
    pixel_t want;
    pixel_t pred;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        pred = blit_texel(in_tdata);
        pixel_q.push_back(typed_pending ? typed_pix : pred);
      end
      if (out_tvalid && out_tready) begin
        got.we    = out_tuser[0];
        got.addr  = out_tdata[19:0];
        got.red   = out_tdata[27:20];
        got.green = out_tdata[35:28];
        got.blue  = out_tdata[43:36];
        got.alpha = out_tdata[51:44];
        got.last  = out_tlast;
        if (pixel_q.size() == 0) begin
          errors = errors + 1;
          $display("%0t: pixel write with nothing expected, expected none, actual %h",
                   $time, got);
        end else begin
          want = pixel_q.pop_front();
          report_field("write_enable", want.we, got.we);
          report_field("pixel_address", want.addr, got.addr);
          report_field("out_red", want.red, got.red);
          report_field("out_green", want.green, got.green);
          report_field("out_blue", want.blue, got.blue);
          report_field("out_alpha", want.alpha, got.alpha);
          report_field("last", want.last, got.last);
        end
      end
    end
  end

  // Stop the run if no transaction moves for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Pixel sink: random stalls, plus a long hold-off on request.
  always @(negedge clk) begin
    if (hold_len > 0) begin
      out_tready <= 1'b0;
      hold_len = hold_len - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  task automatic send_texel(input logic [sbca_pkg::IN_DATA_W-1:0] d, input logic typed,
                            input pixel_t p);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid     <= 1'b1;
    in_tdata      <= d;
    typed_pending = typed;
    typed_pix     = p;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Hold the input and wait until every expected pixel write has come out.
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pixel_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [sbca_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sbca_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      sbca_pkg::REG_SCREEN_WIDTH:  scr_w = val;
      sbca_pkg::REG_SCREEN_HEIGHT: scr_h = val;
      sbca_pkg::REG_SPRITE_WIDTH:  spr_w = val[sbca_pkg::SPR_SIZE_W-1:0];
      sbca_pkg::REG_SPRITE_HEIGHT: spr_h = val[sbca_pkg::SPR_SIZE_W-1:0];
      sbca_pkg::REG_ORIGIN_X:      org_x = val;
      sbca_pkg::REG_ORIGIN_Y:      org_y = val;
      sbca_pkg::REG_BLEND_ENABLE:  blend_on = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    plan_step_t plan[$];
    logic [sbca_pkg::IN_DATA_W-1:0] rnd;
    int k, sw, sh, pw, ph, ox, oy;

    // Texel literals read dst {a,b,g,r} then tex {a,b,g,r}, red in the lowest byte.
    // Reset geometry: 640-wide screen, 64 x 64 sprite at the origin, copy mode.
    plan.push_back(typed_step(64'h8877_6655_4433_2211, 1'b1, 20'd0, 32'h11223344, 1'b0));
    plan.push_back(typed_step(64'h0000_0000_FFFF_FFFF, 1'b1, 20'd1, 32'hFFFFFFFF, 1'b0));
    // Shrink the sprite to 2 x 2 while the column counter already sits at 2.
    plan.push_back(cfg_step(sbca_pkg::REG_SPRITE_WIDTH, 11'd2));
    plan.push_back(cfg_step(sbca_pkg::REG_SPRITE_HEIGHT, 11'd2));
    plan.push_back(typed_step(64'hFFFF_FFFF_0000_0000, 1'b1, 20'd2, 32'h00000000, 1'b0));
    plan.push_back(typed_step(64'h0102_0304_0506_0708, 1'b1, 20'd640, 32'h08070605, 1'b0));
    plan.push_back(typed_step(64'hA5A5_A5A5_5A5A_5A5A, 1'b1, 20'd641, 32'h5A5A5A5A, 1'b1));
    // Sprite one column left of the screen: the first column is clipped.
    plan.push_back(cfg_step(sbca_pkg::REG_ORIGIN_X, 11'h7FF));
    plan.push_back(typed_step(64'h1234_5678_9ABC_DEF0, 1'b0, 20'd0, 32'h00000000, 1'b0));
    plan.push_back(typed_step(64'h1234_5678_9ABC_DEF0, 1'b1, 20'd0, 32'hF0DEBC9A, 1'b0));
    plan.push_back(typed_step(64'h0F0F_0F0F_F0F0_F0F0, 1'b0, 20'd0, 32'h00000000, 1'b0));
    plan.push_back(typed_step(64'h1111_1111_2233_4455, 1'b1, 20'd640, 32'h55443322, 1'b1));
    // Blend mode: transparent, opaque, then mixed alphas.
    plan.push_back(cfg_step(sbca_pkg::REG_ORIGIN_X, 11'd0));
    plan.push_back(cfg_step(sbca_pkg::REG_BLEND_ENABLE, 11'd1));
    plan.push_back(typed_step(64'hFFFF_FFFF_00FF_FFFF, 1'b0, 20'd0, 32'h00000000, 1'b0));
    plan.push_back(typed_step(64'h0000_0000_FF10_2030, 1'b1, 20'd1, 32'h302010FF, 1'b0));
    plan.push_back(texel_step(64'h80C0_4020_80FF_0080));
    plan.push_back(texel_step(64'hFFFF_FFFF_0100_0000));
    plan.push_back(texel_step(64'h0000_0000_FEFF_FFFF));
    // Oversized and zero sizes, extreme origins; upper blend bits are ignored.
    plan.push_back(cfg_step(sbca_pkg::REG_SPRITE_WIDTH, 11'd0));
    plan.push_back(cfg_step(sbca_pkg::REG_SPRITE_HEIGHT, 11'h7FF));
    plan.push_back(cfg_step(sbca_pkg::REG_SCREEN_WIDTH, 11'h7FF));
    plan.push_back(cfg_step(sbca_pkg::REG_SCREEN_HEIGHT, 11'h7FF));
    plan.push_back(cfg_step(sbca_pkg::REG_ORIGIN_X, 11'd1023));
    plan.push_back(cfg_step(sbca_pkg::REG_ORIGIN_Y, 11'd1022));
    plan.push_back(cfg_step(sbca_pkg::REG_BLEND_ENABLE, 11'h7FE));
    plan.push_back(typed_step(64'h0000_0000_FFFF_FFFF, 1'b0, 20'd0, 32'h00000000, 1'b0));
    plan.push_back(typed_step(64'h0000_0000_C3A5_5A3C, 1'b1, 20'hFFFFF, 32'h3C5AA5C3, 1'b0));
    // A write past the register map changes nothing; a zero-wide screen hides all.
    plan.push_back(cfg_step(REG_UNUSED, 11'h7FF));
    plan.push_back(cfg_step(sbca_pkg::REG_SCREEN_WIDTH, 11'd0));
    plan.push_back(cfg_step(sbca_pkg::REG_ORIGIN_X, 11'd0));
    plan.push_back(cfg_step(sbca_pkg::REG_ORIGIN_Y, 11'd0));
    plan.push_back(typed_step(64'h0000_0000_FFFF_FFFF, 1'b0, 20'd0, 32'h00000000, 1'b0));
    plan.push_back(cfg_step(sbca_pkg::REG_SCREEN_WIDTH, 11'd1));
    plan.push_back(typed_step(64'hFFFF_FFFF_0077_8899, 1'b1, 20'd3, 32'h99887700, 1'b0));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        wait_drained();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        send_texel(plan[i].texel, plan[i].typed, plan[i].pix);
      end
    end

    // Random phases, each with fresh geometry and its own idling pattern.
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      case (phase % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 60; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 60; end
        default: begin src_idle_pct = 10; snk_stall_pct = 10; end
      endcase

      // Mostly small screens and sprites so that clipping and sprite ends are frequent.
      k  = $urandom_range(15);
      sw = (k == 0) ? 0 : (k == 1) ? sbca_pkg::MAX_SCREEN_WIDTH :
           (k == 2) ? $urandom_range(1025, 2047) : $urandom_range(1, 40);
      k  = $urandom_range(15);
      sh = (k == 0) ? 0 : (k == 1) ? sbca_pkg::MAX_SCREEN_HEIGHT :
           (k == 2) ? $urandom_range(1025, 2047) : $urandom_range(1, 40);
      k  = $urandom_range(15);
      pw = (k == 0) ? 0 : (k == 1) ? sbca_pkg::MAX_SPRITE_WIDTH :
           (k == 2) ? $urandom_range(257, 2047) : $urandom_range(1, 12);
      k  = $urandom_range(15);
      ph = (k == 0) ? 0 : (k == 1) ? sbca_pkg::MAX_SPRITE_HEIGHT :
           (k == 2) ? $urandom_range(257, 2047) : $urandom_range(1, 12);
      if ($urandom_range(9) == 0) begin
        ox = $urandom_range(1) ? -1024 : 1023;
      end else begin
        ox = $urandom_range(0, ((sw > sbca_pkg::MAX_SCREEN_WIDTH) ?
                                sbca_pkg::MAX_SCREEN_WIDTH : sw) + 24);
        ox = ox - 16;
      end
      if ($urandom_range(9) == 0) begin
        oy = $urandom_range(1) ? -1024 : 1023;
      end else begin
        oy = $urandom_range(0, ((sh > sbca_pkg::MAX_SCREEN_HEIGHT) ?
                                sbca_pkg::MAX_SCREEN_HEIGHT : sh) + 24);
        oy = oy - 16;
      end
      if (ox > 1023) ox = 1023;
      if (oy > 1023) oy = 1023;

      write_reg(sbca_pkg::REG_SCREEN_WIDTH, sbca_pkg::CFG_DATA_W'(sw));
      write_reg(sbca_pkg::REG_SCREEN_HEIGHT, sbca_pkg::CFG_DATA_W'(sh));
      write_reg(sbca_pkg::REG_SPRITE_WIDTH, sbca_pkg::CFG_DATA_W'(pw));
      write_reg(sbca_pkg::REG_SPRITE_HEIGHT, sbca_pkg::CFG_DATA_W'(ph));
      write_reg(sbca_pkg::REG_ORIGIN_X, sbca_pkg::CFG_DATA_W'(ox));
      write_reg(sbca_pkg::REG_ORIGIN_Y, sbca_pkg::CFG_DATA_W'(oy));
      write_reg(sbca_pkg::REG_BLEND_ENABLE, sbca_pkg::CFG_DATA_W'($urandom_range(2047)));
      if ($urandom_range(3) == 0) begin
        write_reg(REG_UNUSED, sbca_pkg::CFG_DATA_W'($urandom_range(2047)));
      end

      // Hold the sink off while the source keeps offering, so the input backs up.
      if (phase == 4) begin
        @(posedge clk);
        hold_len = 300;
      end

      repeat (TEXELS_PER_PHASE) begin
        rnd = {$urandom, $urandom};
        case ($urandom_range(3))
          0: rnd[31:24] = sbca_pkg::ALPHA_CLEAR;
          1: rnd[31:24] = sbca_pkg::ALPHA_OPAQUE;
          default: ;
        endcase
        send_texel(rnd, 1'b0, '0);
      end
    end

    wait_drained();
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/sbca_pkg.sv
hw/rtl/sbca_front.sv
hw/rtl/sbca_queue.sv
hw/rtl/sbca_back.sv
hw/rtl/sprite_blit_clip_alpha.sv
tb/tb_sprite_blit_clip_alpha.sv
